// File: hdl/dssl_pkg.sv
package dssl_pkg;

   localparam int ENTRY_COUNT_DEF = 64;

   localparam logic [0:0] CMD_INSERT = 1'b0;
   localparam logic [0:0] CMD_DRAIN  = 1'b1;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_ENTRY  = 2'd1;
   localparam logic [1:0] KIND_EMPTY  = 2'd2;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_CULLED = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   localparam logic [2:0] REG_CAM_X       = 3'd0;
   localparam logic [2:0] REG_CAM_Y       = 3'd1;
   localparam logic [2:0] REG_BORDER_X    = 3'd2;
   localparam logic [2:0] REG_BORDER_Y    = 3'd3;
   localparam logic [2:0] REG_SHADOW_MASK = 3'd4;

   localparam logic signed [15:0] CAM_X_RESET       = 16'sd320;
   localparam logic signed [15:0] CAM_Y_RESET       = 16'sd240;
   localparam logic [9:0]         BORDER_X_RESET    = 10'd32;
   localparam logic [9:0]         BORDER_Y_RESET    = 10'd32;
   localparam logic [7:0]         SHADOW_MASK_RESET = 8'd16;

   localparam logic signed [18:0] HALF_WIDTH    = 19'sd320;
   localparam logic signed [18:0] HALF_HEIGHT   = 19'sd240;
   localparam logic signed [18:0] SCREEN_WIDTH  = 19'sd640;
   localparam logic signed [18:0] SCREEN_HEIGHT = 19'sd480;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [15:0]        hue;
      logic signed [7:0]  bright;
      logic [7:0]         flags;
      logic [15:0]        sprite;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_FIX,
      ST_FINISH,
      ST_DRAIN
   } state_type;

endpackage

// File: hdl/depth_sorted_sprite_list.sv
// Depth-sorted sprite draw list.
// Input channel (req_*): one transfer carries an insert or a drain command.
// An insert is culled against the camera window, stored in the lowest free
// slot and linked into the draw order; it always yields one status transfer.
// A drain yields every entry in draw order with rsp_last on the final one,
// or a single empty marker, and then clears the list.
// Result channel (rsp_*): a registered output stage; the block takes a new
// command while the previous result still waits on rsp_ready.
// An insert is checked; unless it goes to the head, it walks the list entry
// by entry (plus a fix step when it lands between two entries), then finishes.
// A drain emits one entry per cycle while the output is free; each walk or
// drain step waits for the registered read of the entry and link memories at
// the address the previous step returned. When the receiver stalls, the drain
// holds its place and resumes on ready. Reset empties the list and loads the
// default camera and border settings; the memories are not cleared, as slots
// are handed out in order. The user writes configuration (psel/penable/pwrite)
// only while the block idles; the block itself does not enforce this.
module depth_sorted_sprite_list #(
   parameter int ENTRY_COUNT = dssl_pkg::ENTRY_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [0:0]          req_command,
   input  logic signed [15:0]  req_pos_x,
   input  logic signed [15:0]  req_pos_y,
   input  logic signed [15:0]  req_pos_z,
   input  logic [15:0]         req_hue,
   input  logic signed [7:0]   req_bright,
   input  logic [7:0]          req_flags,
   input  logic [15:0]         req_sprite,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [1:0]          rsp_status,
   output logic signed [15:0]  rsp_out_x,
   output logic signed [15:0]  rsp_out_y,
   output logic signed [15:0]  rsp_out_z,
   output logic [15:0]         rsp_out_hue,
   output logic signed [7:0]   rsp_out_bright,
   output logic [7:0]          rsp_out_flags,
   output logic [15:0]         rsp_out_sprite,
   output logic                rsp_last,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import dssl_pkg::*;

   localparam int SLOT_W = $clog2(ENTRY_COUNT);
   localparam int LINK_W = $clog2(ENTRY_COUNT + 1);
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(ENTRY_COUNT);

   logic signed [15:0] cam_x_ff;
   logic signed [15:0] cam_y_ff;
   logic [9:0]         border_x_ff;
   logic [9:0]         border_y_ff;
   logic [7:0]         shadow_mask_ff;
   logic               csr_write;
   logic [2:0]         csr_index;

   state_type          state_ff, state_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [LINK_W-1:0]  count_ff, count_in;
   logic [LINK_W-1:0]  prev_ff, prev_in;
   logic [SLOT_W-1:0]  me_ff, me_in;
   logic [SLOT_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [1:0]         fin_kind_ff, fin_kind_in;
   logic [1:0]         status_ff, status_in;
   entry_type          req_ff, req_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   entry_type          rsp_entry_ff, rsp_entry_in;
   logic               rsp_last_ff, rsp_last_in;

   entry_type          ent_mem [ENTRY_COUNT];
   entry_type          ent_rd_ff;
   logic               ent_we;
   logic [LINK_W-1:0]  lnk_mem [ENTRY_COUNT];
   logic [LINK_W-1:0]  lnk_rd_ff;
   logic               lnk_we;
   logic [SLOT_W-1:0]  lnk_waddr;
   logic [LINK_W-1:0]  lnk_wdata;

   logic signed [18:0] off_x, off_y, bx_s, by_s;
   logic               culled;
   logic               req_shadow;
   logic               cur_shadow;
   logic               cur_after;
   logic               next_null;
   logic               out_free;

   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[4:2];
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff       <= CAM_X_RESET;
         cam_y_ff       <= CAM_Y_RESET;
         border_x_ff    <= BORDER_X_RESET;
         border_y_ff    <= BORDER_Y_RESET;
         shadow_mask_ff <= SHADOW_MASK_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_CAM_X:       cam_x_ff       <= pwdata[15:0];
            REG_CAM_Y:       cam_y_ff       <= pwdata[15:0];
            REG_BORDER_X:    border_x_ff    <= pwdata[9:0];
            REG_BORDER_Y:    border_y_ff    <= pwdata[9:0];
            REG_SHADOW_MASK: shadow_mask_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CAM_X:       prdata = {16'd0, cam_x_ff};
         REG_CAM_Y:       prdata = {16'd0, cam_y_ff};
         REG_BORDER_X:    prdata = {22'd0, border_x_ff};
         REG_BORDER_Y:    prdata = {22'd0, border_y_ff};
         REG_SHADOW_MASK: prdata = {24'd0, shadow_mask_ff};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[count_ff[SLOT_W-1:0]] <= req_ff;
      end
      ent_rd_ff <= ent_mem[rd_addr_in];
   end

   always_ff @(posedge clock) begin
      if (lnk_we) begin
         lnk_mem[lnk_waddr] <= lnk_wdata;
      end
      lnk_rd_ff <= lnk_mem[rd_addr_in];
   end

   assign bx_s  = {9'd0, border_x_ff};
   assign by_s  = {9'd0, border_y_ff};
   assign off_x = {{3{req_ff.x[15]}}, req_ff.x} - {{3{cam_x_ff[15]}}, cam_x_ff} + HALF_WIDTH;
   assign off_y = {{3{req_ff.y[15]}}, req_ff.y} - {{3{cam_y_ff[15]}}, cam_y_ff} + HALF_HEIGHT;
   assign culled = (off_x < -bx_s) || (off_x > SCREEN_WIDTH + bx_s)
                || (off_y < -by_s) || (off_y > SCREEN_HEIGHT + by_s);

   assign req_shadow = |(req_ff.flags & shadow_mask_ff);
   assign cur_shadow = |(ent_rd_ff.flags & shadow_mask_ff);
   assign cur_after  = !cur_shadow && ((ent_rd_ff.y > req_ff.y)
                    || ((ent_rd_ff.y == req_ff.y) && (ent_rd_ff.z > req_ff.z)));
   assign next_null  = (lnk_rd_ff >= LINK_NULL);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      prev_in       = prev_ff;
      me_in         = me_ff;
      rd_addr_in    = rd_addr_ff;
      fin_kind_in   = fin_kind_ff;
      status_in     = status_ff;
      req_in        = req_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;
      ent_we        = 1'b0;
      lnk_we        = 1'b0;
      lnk_waddr     = me_ff;
      lnk_wdata     = LINK_NULL;
      req_ready     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = '{x: req_pos_x, y: req_pos_y, z: req_pos_z, hue: req_hue,
                          bright: req_bright, flags: req_flags, sprite: req_sprite};
               if (req_command == CMD_INSERT) begin
                  state_in = ST_CHECK;
               end else if (head_ff >= LINK_NULL) begin
                  fin_kind_in = KIND_EMPTY;
                  status_in   = STATUS_OK;
                  head_in     = LINK_NULL;
                  count_in    = '0;
                  state_in    = ST_FINISH;
               end else begin
                  rd_addr_in = head_ff[SLOT_W-1:0];
                  state_in   = ST_DRAIN;
               end
            end
         end

         ST_CHECK: begin
            fin_kind_in = KIND_STATUS;
            if (culled) begin
               status_in = STATUS_CULLED;
               state_in  = ST_FINISH;
            end else if (count_ff == LINK_NULL) begin
               status_in = STATUS_FULL;
               state_in  = ST_FINISH;
            end else begin
               status_in = STATUS_OK;
               ent_we    = 1'b1;
               me_in     = count_ff[SLOT_W-1:0];
               count_in  = count_ff + 1'b1;
               lnk_we    = 1'b1;
               lnk_waddr = count_ff[SLOT_W-1:0];
               if ((head_ff >= LINK_NULL) || req_shadow) begin
                  lnk_wdata = head_ff;
                  head_in   = count_ff;
                  state_in  = ST_FINISH;
               end else begin
                  lnk_wdata  = LINK_NULL;
                  prev_in    = LINK_NULL;
                  rd_addr_in = head_ff[SLOT_W-1:0];
                  state_in   = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (cur_after) begin
               lnk_we = 1'b1;
               if (prev_ff >= LINK_NULL) begin
                  lnk_waddr = me_ff;
                  lnk_wdata = LINK_W'(rd_addr_ff);
                  head_in   = LINK_W'(me_ff);
                  state_in  = ST_FINISH;
               end else begin
                  lnk_waddr = prev_ff[SLOT_W-1:0];
                  lnk_wdata = LINK_W'(me_ff);
                  state_in  = ST_FIX;
               end
            end else if (next_null) begin
               lnk_we    = 1'b1;
               lnk_waddr = rd_addr_ff;
               lnk_wdata = LINK_W'(me_ff);
               state_in  = ST_FINISH;
            end else begin
               prev_in    = LINK_W'(rd_addr_ff);
               rd_addr_in = lnk_rd_ff[SLOT_W-1:0];
            end
         end

         ST_FIX: begin
            lnk_we    = 1'b1;
            lnk_waddr = me_ff;
            lnk_wdata = LINK_W'(rd_addr_ff);
            state_in  = ST_FINISH;
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = fin_kind_ff;
               rsp_status_in = status_ff;
               rsp_entry_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_ENTRY;
               rsp_status_in = STATUS_OK;
               rsp_entry_in  = ent_rd_ff;
               rsp_last_in   = next_null;
               if (next_null) begin
                  head_in  = LINK_NULL;
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  rd_addr_in = lnk_rd_ff[SLOT_W-1:0];
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= LINK_NULL;
         count_ff     <= '0;
         prev_ff      <= LINK_NULL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      me_ff         <= me_in;
      rd_addr_ff    <= rd_addr_in;
      fin_kind_ff   <= fin_kind_in;
      status_ff     <= status_in;
      req_ff        <= req_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_x      = rsp_entry_ff.x;
   assign rsp_out_y      = rsp_entry_ff.y;
   assign rsp_out_z      = rsp_entry_ff.z;
   assign rsp_out_hue    = rsp_entry_ff.hue;
   assign rsp_out_bright = rsp_entry_ff.bright;
   assign rsp_out_flags  = rsp_entry_ff.flags;
   assign rsp_out_sprite = rsp_entry_ff.sprite;
   assign rsp_last       = rsp_last_ff;

endmodule
